>>> hdl/mots_pkg.sv
`timescale 1ns / 1ps

package mots_pkg;

  localparam int DataW = 32;
  localparam int MedW  = DataW + 1;

  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [MedW-1:0] median_doubled;
    logic [1:0]             status;
  } result_t;

endpackage

>>> hdl/mots_store.sv
`timescale 1ns / 1ps

module mots_store
  import mots_pkg::*;
#(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [DataW-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr0_i,
  input  logic [AddrW-1:0]        raddr1_i,
  output logic signed [DataW-1:0] rdata0_o,
  output logic signed [DataW-1:0] rdata1_o
);

  logic signed [DataW-1:0] mem [Depth];
  logic signed [DataW-1:0] rdata0_q;
  logic signed [DataW-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

>>> hdl/median_of_two_sorted_arrays.sv
`timescale 1ns / 1ps
// Median of two sorted stores. Load transfers (opcode 0 or 1) may follow
// back to back; busy stays low through them. A compute transfer raises
// busy through a setup state, k partition search steps and a final state,
// where k is at most floor(log2(m+1)) + 1 for a shorter store of m values;
// each step is a read of both stores' registered memories followed by a
// compare. With both stores empty busy is high for a single cycle. The
// result appears on result_o with done_o, which is high for exactly one
// cycle, in the cycle in which busy falls, and must be taken then; result_o
// keeps it until the next compute ends. Stores are to be loaded in ascending order.

module median_of_two_sorted_arrays
  import mots_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  req_t    req_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  localparam int CntW  = $clog2(STORE_DEPTH + 1);
  localparam int AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] first_cnt_q, first_cnt_d;
  logic [CntW-1:0] second_cnt_q, second_cnt_d;
  logic            ovf_q, ovf_d;
  logic            swap_q, swap_d;
  logic [CntW-1:0] m_q, m_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] half_q, half_d;
  logic [CntW-1:0] lo_q, lo_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic            done_q, done_d;
  result_t         result_q, result_d;

  logic            accept;
  logic            first_we;
  logic            second_we;
  logic            store_re;
  logic [CntW:0]   pos_sum;
  logic [CntW:0]   tot_sum;
  logic [CntW-1:0] i_sel;
  logic [CntW-1:0] j_sel;
  logic [CntW-1:0] a_lo_idx;
  logic [CntW-1:0] b_lo_idx;
  logic [AddrW-1:0] first_ra0, first_ra1, second_ra0, second_ra1;
  logic signed [DataW-1:0] first_rd0, first_rd1, second_rd0, second_rd1;
  logic signed [DataW-1:0] a_lo, a_hi, b_lo, b_hi;
  logic signed [DataW-1:0] left_v, right_v;
  logic [CntW-1:0] lo_next;
  logic [CntW-1:0] hi_next;
  logic            go_right;
  logic            go_left;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign first_we  = accept && (req_i.opcode == OP_LOAD_FIRST)
                     && (first_cnt_q != CntW'(STORE_DEPTH));
  assign second_we = accept && (req_i.opcode == OP_LOAD_SECOND)
                     && (second_cnt_q != CntW'(STORE_DEPTH));
  assign store_re  = (state_q == S_READ);

  assign pos_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign i_sel    = pos_sum[CntW:1];
  assign j_sel    = half_q - i_sel;
  assign a_lo_idx = i_sel - CntW'(1);
  assign b_lo_idx = j_sel - CntW'(1);

  assign first_ra0  = swap_q ? b_lo_idx[AddrW-1:0] : a_lo_idx[AddrW-1:0];
  assign first_ra1  = swap_q ? j_sel[AddrW-1:0]    : i_sel[AddrW-1:0];
  assign second_ra0 = swap_q ? a_lo_idx[AddrW-1:0] : b_lo_idx[AddrW-1:0];
  assign second_ra1 = swap_q ? i_sel[AddrW-1:0]    : j_sel[AddrW-1:0];

  mots_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_first_store (
    .clk_i    (clk_i),
    .we_i     (first_we),
    .waddr_i  (first_cnt_q[AddrW-1:0]),
    .wdata_i  (req_i.value),
    .re_i     (store_re),
    .raddr0_i (first_ra0),
    .raddr1_i (first_ra1),
    .rdata0_o (first_rd0),
    .rdata1_o (first_rd1)
  );

  mots_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_second_store (
    .clk_i    (clk_i),
    .we_i     (second_we),
    .waddr_i  (second_cnt_q[AddrW-1:0]),
    .wdata_i  (req_i.value),
    .re_i     (store_re),
    .raddr0_i (second_ra0),
    .raddr1_i (second_ra1),
    .rdata0_o (second_rd0),
    .rdata1_o (second_rd1)
  );

  // Zero out reads that fall outside the stored range.
  always_comb begin
    a_lo = '0;
    a_hi = '0;
    b_lo = '0;
    b_hi = '0;
    if (i_q != '0) begin
      a_lo = swap_q ? second_rd0 : first_rd0;
    end
    if (i_q < m_q) begin
      a_hi = swap_q ? second_rd1 : first_rd1;
    end
    if (j_q != '0) begin
      b_lo = swap_q ? first_rd0 : second_rd0;
    end
    if (j_q < n_q) begin
      b_hi = swap_q ? first_rd1 : second_rd1;
    end
  end

  assign lo_next  = i_q + CntW'(1);
  assign hi_next  = i_q - CntW'(1);
  assign go_right = (i_q < m_q) && (b_lo > a_hi);
  assign go_left  = (i_q != '0) && (a_lo > b_hi);
  assign tot_sum  = {1'b0, first_cnt_q} + {1'b0, second_cnt_q} + (CntW + 1)'(1);

  always_comb begin
    if (i_q == '0) begin
      left_v = b_lo;
    end else if (j_q == '0) begin
      left_v = a_lo;
    end else begin
      left_v = (a_lo > b_lo) ? a_lo : b_lo;
    end
    if (i_q == m_q) begin
      right_v = b_hi;
    end else if (j_q == n_q) begin
      right_v = a_hi;
    end else begin
      right_v = (a_hi < b_hi) ? a_hi : b_hi;
    end
  end

  always_comb begin
    state_d      = state_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    ovf_d        = ovf_q;
    swap_d       = swap_q;
    m_d          = m_q;
    n_d          = n_q;
    half_d       = half_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    i_d          = i_q;
    j_d          = j_q;
    done_d       = 1'b0;
    result_d     = result_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            OP_LOAD_FIRST: begin
              if (first_we) begin
                first_cnt_d = first_cnt_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_LOAD_SECOND: begin
              if (second_we) begin
                second_cnt_d = second_cnt_q + CntW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_COMPUTE: begin
              state_d = S_SETUP;
            end
            default: begin
            end
          endcase
        end
      end
      S_SETUP: begin
        swap_d = (second_cnt_q < first_cnt_q);
        m_d    = swap_d ? second_cnt_q : first_cnt_q;
        n_d    = swap_d ? first_cnt_q : second_cnt_q;
        half_d = tot_sum[CntW:1];
        lo_d   = '0;
        hi_d   = m_d;
        if ((first_cnt_q == '0) && (second_cnt_q == '0)) begin
          result_d.median_doubled = '0;
          result_d.status         = STATUS_EMPTY;
          done_d                  = 1'b1;
          ovf_d                   = 1'b0;
          state_d                 = S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        i_d     = i_sel;
        j_d     = j_sel;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (go_right) begin
          lo_d    = lo_next;
          state_d = (lo_next <= hi_q) ? S_READ : S_FINAL;
        end else if (go_left) begin
          hi_d    = hi_next;
          state_d = (lo_q <= hi_next) ? S_READ : S_FINAL;
        end else begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (m_q[0] ^ n_q[0]) begin
          result_d.median_doubled = {left_v, 1'b0};
        end else begin
          result_d.median_doubled = {left_v[DataW-1], left_v}
                                    + {right_v[DataW-1], right_v};
        end
        result_d.status = ovf_q ? STATUS_OVERFLOW : STATUS_OK;
        done_d          = 1'b1;
        first_cnt_d     = '0;
        second_cnt_d    = '0;
        ovf_d           = 1'b0;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      ovf_q        <= ovf_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    swap_q   <= swap_d;
    m_q      <= m_d;
    n_q      <= n_d;
    half_q   <= half_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    i_q      <= i_d;
    j_q      <= j_d;
    result_q <= result_d;
  end

  // Clear both counts after each compute, in the empty case as well.
  // (Empty case leaves them zero already.)

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

>>> hdl/mots_checker.sv
`timescale 1ns / 1ps

module mots_checker
  import mots_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input req_t    req_i,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  a_compute_raises_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.opcode == OP_COMPUTE)) |=> busy
  ) else $error("compute transfer did not raise busy");

  a_done_after_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)
  ) else $error("result strobe without a preceding compute");

  a_done_single: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o
  ) else $error("result strobe held for more than one cycle");

  a_empty_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STATUS_EMPTY)) |-> (result_o.median_doubled == '0)
  ) else $error("empty status with nonzero median");

endmodule

bind median_of_two_sorted_arrays mots_checker u_mots_checker (.*);
